@@ src/natt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// natt_pkg: shared types and codes for the translation table
// Status, function and register codes and sequencer states.
// ----------------------------------------------------------------------------
package natt_pkg;
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TICK     = 3'd4;

	localparam logic [1:0] FN_OUT  = 2'd0;
	localparam logic [1:0] FN_IN   = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	localparam logic [1:0] REG_TIMEOUT  = 2'd0;
	localparam logic [1:0] REG_MIN_PORT = 2'd1;
	localparam logic [1:0] REG_MAX_PORT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_EXPIRE,
		S_PORT_INIT,
		S_PORT_SCAN,
		S_STORE,
		S_READ,
		S_READ2,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

@@ src/nat_translation_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_translation_table: address and port translation table
// Outbound lookup or new mapping, inbound lookup, and a seconds tick.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries func and the packet fields; output
// channel out_valid/out_ready carries one result per item. Configuration is
// a plain write port (cfg_we, cfg_index, cfg_data), used while idle.
// One item at a time: a sequencer walks the slots one per cycle through a
// single shared compare unit and slot memory port.
// A tick or an unknown func goes straight to the done state. An inbound item
// walks the slots until a live match or the last slot; a hit in either
// direction stops the walk and reads the matching slot back.
// An outbound miss walks the slots once to look up and once to expire, then
// probes port candidates, each probe a walk over the slots, for at most
// ENTRIES probes, then stores the mapping and reads it back. A full table or
// an empty port range answers after the expiry walk, or after all probes.
// in_ready is high only in the idle state with the output register empty;
// the result waits there until taken, and the next item is accepted from the
// cycle after that transfer.
// Reset clears all valid bits and the seconds clock, sets the port candidate
// to 1024 and loads the configuration defaults; slot contents stay unknown.
// ----------------------------------------------------------------------------
module nat_translation_table #(
	parameter int ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] host_ip,
	input  wire logic [47:0] host_mac,
	input  wire logic [15:0] host_port,
	input  wire logic [31:0] peer_ip,
	input  wire logic [15:0] mapped_port,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [47:0]      out_mac,
	output logic [31:0]      out_host_ip,
	output logic [15:0]      out_host_port,
	output logic [31:0]      out_peer_ip,
	output logic [15:0]      out_mapped_port,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import natt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

	// slot memory (one read port, one write port)
	logic [47:0] mem_mac   [ENTRIES];
	logic [31:0] mem_iip   [ENTRIES];
	logic [15:0] mem_ipt   [ENTRIES];
	logic [31:0] mem_rip   [ENTRIES];
	logic [15:0] mem_port  [ENTRIES];
	logic [31:0] mem_seen  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [15:0] timeout_q, min_q, max_q;
	logic [31:0] now_q;
	logic [15:0] cand_q, c_q;
	logic [1:0]  func_q;
	logic [31:0] iip_q, rip_q;
	logic [47:0] mac_q;
	logic [15:0] ipt_q, ept_q;
	state_t      state_q, state_d;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] tries_q;
	logic [IW-1:0] hit_q;
	logic [2:0]  st_q;

	// registered read data
	logic [47:0] r_mac;
	logic [31:0] r_iip, r_rip, r_seen;
	logic [15:0] r_ipt, r_port;
	logic [IW-1:0] raddr;

	logic          r_ok;
	logic          match_out, match_in, expired, used;
	logic [31:0]   age;
	logic          free_any;
	logic [IW-1:0] free_idx;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign age      = now_q - r_seen;
	assign expired  = age > {16'd0, timeout_q};
	assign match_out = (r_iip == iip_q) && (r_ipt == ipt_q) && (r_rip == rip_q);
	assign match_in  = (r_rip == rip_q) && (r_port == ept_q) && !expired;
	assign used      = (r_port == c_q);

	// lowest free slot (priority over valid bits)
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// the read address is idx itself and the registered read data trails it,
	// marked by r_ok; hold the chosen slot through S_READ and S_READ2
	always_comb begin
		raddr = idx_q[IW-1:0];
		if (state_q == S_READ || state_q == S_READ2) raddr = hit_q;
	end

	always_ff @(posedge clk) begin
		r_mac  <= mem_mac[raddr];
		r_iip  <= mem_iip[raddr];
		r_ipt  <= mem_ipt[raddr];
		r_rip  <= mem_rip[raddr];
		r_port <= mem_port[raddr];
		r_seen <= mem_seen[raddr];
	end

	// write memory: refresh on hit, full store on new mapping
	always_ff @(posedge clk) begin
		if (state_q == S_STORE) begin
			mem_mac[free_idx]  <= mac_q;
			mem_iip[free_idx]  <= iip_q;
			mem_ipt[free_idx]  <= ipt_q;
			mem_rip[free_idx]  <= rip_q;
			mem_port[free_idx] <= c_q;
			mem_seen[free_idx] <= now_q;
		end else if (state_q == S_LOOK && r_ok && valid_q[idx_q[IW-1:0] - IW'(1)] &&
			((func_q == FN_OUT) ? match_out : match_in)) begin
			mem_seen[idx_q[IW-1:0] - IW'(1)] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		logic [IW-1:0] pi;
		pi = idx_q[IW-1:0] - IW'(1);
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (func == FN_OUT || func == FN_IN) state_d = S_LOOK;
					else state_d = S_DONE;
				end
			end
			S_LOOK: begin
				if (r_ok && valid_q[pi] &&
					((func_q == FN_OUT) ? match_out : match_in))
					state_d = S_READ;
				else if (r_ok && pi == IW'(ENTRIES - 1))
					state_d = (func_q == FN_OUT) ? S_EXPIRE : S_DONE;
			end
			S_EXPIRE: begin
				if (r_ok && pi == IW'(ENTRIES - 1)) state_d = S_PORT_INIT;
			end
			S_PORT_INIT: begin
				if (!free_any || min_q >= max_q) state_d = S_DONE;
				else state_d = S_PORT_SCAN;
			end
			S_PORT_SCAN: begin
				if (r_ok && valid_q[pi] && used) begin
					if (tries_q == LAST) state_d = S_DONE;
				end else if (r_ok && pi == IW'(ENTRIES - 1)) begin
					state_d = S_STORE;
				end
			end
			S_STORE: state_d = S_READ;
			S_READ:  state_d = S_READ2;
			S_READ2: state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			timeout_q <= 16'd300;
			min_q     <= 16'd1024;
			max_q     <= 16'd65535;
			now_q     <= '0;
			cand_q    <= 16'd1024;
			out_valid <= 1'b0;
			idx_q     <= '0;
			tries_q   <= '0;
			r_ok      <= 1'b0;
			st_q      <= ST_NOTFOUND;
			hit_q     <= '0;
		end else begin
			logic [IW-1:0] pi;
			logic [15:0]   cn;
			logic [CW-1:0] idx_n;
			logic          ok_n;
			pi = idx_q[IW-1:0] - IW'(1);
			cn = c_q + 16'd1;
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT:  timeout_q <= cfg_data;
					REG_MIN_PORT: min_q     <= cfg_data;
					REG_MAX_PORT: max_q     <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			// advance the slot walk: idx leads the registered read by one slot
			idx_n = idx_q;
			ok_n  = 1'b0;
			if (idx_q != CW'(ENTRIES)) begin
				idx_n = idx_q + CW'(1);
				ok_n  = 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					idx_n = '0;
					ok_n  = 1'b0;
					if (in_valid && in_ready) begin
						if (func == FN_TICK) begin
							now_q <= now_q + 32'd1;
							st_q  <= ST_TICK;
						end else begin
							st_q <= ST_NOTFOUND;
						end
					end
				end
				S_LOOK: begin
					if (r_ok && valid_q[pi] &&
						((func_q == FN_OUT) ? match_out : match_in)) begin
						hit_q <= pi;
						st_q  <= ST_HIT;
					end else if (r_ok && pi == IW'(ENTRIES - 1)) begin
						idx_n = '0;
						ok_n  = 1'b0;
					end
				end
				S_EXPIRE: begin
					if (r_ok && valid_q[pi] && expired) valid_q[pi] <= 1'b0;
				end
				S_PORT_INIT: begin
					st_q    <= ST_FULL;
					tries_q <= '0;
					idx_n   = '0;
					ok_n    = 1'b0;
					c_q     <= (cand_q < min_q || cand_q >= max_q) ? min_q : cand_q;
				end
				S_PORT_SCAN: begin
					if (r_ok && valid_q[pi] && used) begin
						// candidate taken: try the next one from slot zero
						c_q     <= (cn < min_q || cn >= max_q) ? min_q : cn;
						tries_q <= tries_q + CW'(1);
						idx_n   = '0;
						ok_n    = 1'b0;
					end
				end
				S_STORE: begin
					valid_q[free_idx] <= 1'b1;
					hit_q   <= free_idx;
					st_q    <= ST_NEW;
					cand_q  <= (cn >= max_q) ? min_q : cn;
				end
				S_DONE: out_valid <= 1'b1;
				default: ;
			endcase
			idx_q <= idx_n;
			r_ok  <= ok_n;
		end
	end

	// capture the item and build the result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			iip_q  <= host_ip;
			mac_q  <= host_mac;
			ipt_q  <= host_port;
			rip_q  <= peer_ip;
			ept_q  <= mapped_port;
		end
		if (state_q == S_DONE) begin
			status <= st_q;
			if (st_q == ST_HIT || st_q == ST_NEW) begin
				out_mac         <= r_mac;
				out_host_ip     <= r_iip;
				out_host_port   <= r_ipt;
				out_peer_ip     <= r_rip;
				out_mapped_port <= r_port;
			end else begin
				out_mac         <= '0;
				out_host_ip     <= '0;
				out_host_port   <= '0;
				out_peer_ip     <= '0;
				out_mapped_port <= '0;
			end
		end
	end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the address and port translation table
// Drives a directed table and then random traffic (flows reused so lookups
// hit, inbound probes on handed-out ports, ticks to age slots) over several
// register settings. Each result is checked field by field against an in-bench
// model (typed rows: given status, zero fields), with random handshake gaps.
// ----------------------------------------------------------------------------
module tb;
	import natt_pkg::*;

	localparam int          SLOTS    = 16;
	localparam logic [1:0]  FN_RSVD  = 2'd3;
	localparam int          N_RANDOM = 1250;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] iip;
		logic [47:0] mac;
		logic [15:0] ipt;
		logic [31:0] rip;
		logic [15:0] ept;
	} pkt_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] mac;
		logic [31:0] iip;
		logic [15:0] ipt;
		logic [31:0] rip;
		logic [15:0] ept;
	} xlat_t;

	typedef struct {
		pkt_t       pkt;
		bit         typed;
		logic [2:0] status;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [31:0] host_ip = '0;
	logic [47:0] host_mac = '0;
	logic [15:0] host_port = '0;
	logic [31:0] peer_ip = '0;
	logic [15:0] mapped_port = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [47:0] out_mac;
	logic [31:0] out_host_ip;
	logic [15:0] out_host_port;
	logic [31:0] out_peer_ip;
	logic [15:0] out_mapped_port;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	nat_translation_table #(.ENTRIES(SLOTS)) dut (.*);

	always #5 clk = ~clk;

	// table model state
	logic        m_valid [SLOTS];
	logic [47:0] m_mac [SLOTS];
	logic [31:0] m_iip [SLOTS];
	logic [15:0] m_ipt [SLOTS];
	logic [31:0] m_rip [SLOTS];
	logic [15:0] m_port [SLOTS];
	logic [31:0] m_seen [SLOTS];
	logic [31:0] m_now;
	logic [15:0] m_cand;
	logic [15:0] m_timeout, m_min, m_max;

	xlat_t pending[$];
	pkt_t  flow_pool[$];
	pkt_t  port_pool[$];
	row_t  dir_rows[$];
	int    errors = 0;
	bit    calm = 0;

	function automatic xlat_t slot_result(logic [2:0] st, int i);
		xlat_t r;
		r.status = st;
		r.mac = m_mac[i];
		r.iip = m_iip[i];
		r.ipt = m_ipt[i];
		r.rip = m_rip[i];
		r.ept = m_port[i];
		return r;
	endfunction

	function automatic bit aged_out(int i);
		logic [31:0] age;
		age = m_now - m_seen[i];
		return age > {16'd0, m_timeout};
	endfunction

	// Compute the result of one item and advance the table model.
	function automatic xlat_t translate(pkt_t p);
		xlat_t       r;
		int          hit, free_slot;
		bit          found, used;
		int unsigned c;
		logic [15:0] port;
		r = '0;
		hit = -1;
		free_slot = -1;
		found = 0;
		port = '0;
		case (p.func)
			FN_OUT: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && m_valid[i] && m_iip[i] == p.iip && m_ipt[i] == p.ipt &&
					    m_rip[i] == p.rip)
						hit = i;
				if (hit >= 0) begin
					m_seen[hit] = m_now;
					r = slot_result(ST_HIT, hit);
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (m_valid[i] && aged_out(i))
							m_valid[i] = 1'b0;
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!m_valid[i])
							free_slot = i;
					if (free_slot >= 0 && m_min < m_max) begin
						c = m_cand;
						for (int t = 0; t < SLOTS && !found; t++) begin
							if (c < m_min || c >= m_max)
								c = m_min;
							used = 0;
							for (int j = 0; j < SLOTS; j++)
								if (m_valid[j] && m_port[j] == c)
									used = 1;
							if (!used) begin
								port = c[15:0];
								found = 1;
								c = c + 1;
								m_cand = (c >= m_max) ? m_min : c[15:0];
							end else begin
								c = c + 1;
							end
						end
					end
					if (!found) begin
						r.status = ST_FULL;
					end else begin
						m_valid[free_slot] = 1'b1;
						m_mac[free_slot] = p.mac;
						m_iip[free_slot] = p.iip;
						m_ipt[free_slot] = p.ipt;
						m_rip[free_slot] = p.rip;
						m_port[free_slot] = port;
						m_seen[free_slot] = m_now;
						r = slot_result(ST_NEW, free_slot);
					end
				end
			end
			FN_IN: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && m_valid[i] && m_rip[i] == p.rip && m_port[i] == p.ept &&
					    !aged_out(i))
						hit = i;
				if (hit >= 0) begin
					m_seen[hit] = m_now;
					r = slot_result(ST_HIT, hit);
				end else begin
					r.status = ST_NOTFOUND;
				end
			end
			FN_TICK: begin
				m_now = m_now + 1;
				r.status = ST_TICK;
			end
			default: r.status = ST_NOTFOUND;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Transfer one item after a gap; returns at the edge where it is accepted.
	task automatic send(pkt_t p, int gap, bit typed = 0, logic [2:0] st = '0);
		xlat_t r;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= p.func;
		host_ip <= p.iip;
		host_mac <= p.mac;
		host_port <= p.ipt;
		peer_ip <= p.rip;
		mapped_port <= p.ept;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = translate(p);
		if (typed) begin
			r = '0;
			r.status = st;
		end
		pending.push_back(r);
		// remember flows and ports so later traffic hits them
		if (r.status == ST_NEW) begin
			flow_pool.push_back(p);
			port_pool.push_back('{FN_IN, 32'd0, 48'd0, 16'd0, r.rip, r.ept});
			if (flow_pool.size() > 48) void'(flow_pool.pop_front());
			if (port_pool.size() > 48) void'(port_pool.pop_front());
		end
	endtask

	// Write one register, then leave the port idle before returning.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUT:  m_timeout = val;
			REG_MIN_PORT: m_min = val;
			REG_MAX_PORT: m_max = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_row(logic [1:0] f, logic [31:0] iip, logic [47:0] mac, logic [15:0] ipt,
	                       logic [31:0] rip, logic [15:0] ept, bit typed, logic [2:0] st);
		row_t r;
		r.pkt = '{f, iip, mac, ipt, rip, ept};
		r.typed = typed;
		r.status = st;
		dir_rows.push_back(r);
	endtask

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic [31:0] pick_ip();
		return ($urandom_range(0, 2) == 0) ? 32'(32'hC0A8_0000 + $urandom_range(0, 3)) : $urandom;
	endfunction

	function automatic pkt_t random_item();
		pkt_t p;
		int   r;
		p = '{FN_OUT, pick_ip(), 48'({$urandom, $urandom}), 16'($urandom), pick_ip(),
		      16'($urandom)};
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if (flow_pool.size() != 0 && $urandom_range(0, 99) < 60) begin
				p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
				p.mac = 48'({$urandom, $urandom});
			end
			p.func = FN_OUT;
		end else if (r < 75) begin
			if (port_pool.size() != 0 && $urandom_range(0, 99) < 65) begin
				pkt_t q;
				q = port_pool[$urandom_range(0, port_pool.size() - 1)];
				p.rip = q.rip;
				p.ept = ($urandom_range(0, 5) == 0) ? 16'(q.ept + 1) : q.ept;
			end
			p.func = FN_IN;
		end else if (r < 97) begin
			p.func = FN_TICK;
		end else begin
			p.func = FN_RSVD;
		end
		return p;
	endfunction

	// Accept results and check them against the oldest expectation.
	initial begin
		int    stall;
		xlat_t want;
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(status), 64'd0);
			end else begin
				want = pending.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (out_mac !== want.mac)
					report_mismatch("out_mac", 64'(out_mac), 64'(want.mac));
				if (out_host_ip !== want.iip)
					report_mismatch("out_host_ip", 64'(out_host_ip), 64'(want.iip));
				if (out_host_port !== want.ipt)
					report_mismatch("out_host_port", 64'(out_host_port), 64'(want.ipt));
				if (out_peer_ip !== want.rip)
					report_mismatch("out_peer_ip", 64'(out_peer_ip), 64'(want.rip));
				if (out_mapped_port !== want.ept)
					report_mismatch("out_mapped_port", 64'(out_mapped_port), 64'(want.ept));
			end
		end
	end

	// Stimulus: directed table, then random phases over register settings.
	initial begin
		logic [15:0] phase_cfg [7][3];
		int per_phase;
		phase_cfg = '{
			'{16'd300,   16'd1024,  16'd65535},
			'{16'd4,     16'd100,   16'd120},
			'{16'd1,     16'd65534, 16'd65535},
			'{16'd65535, 16'd1,     16'd2},
			'{16'd10,    16'd2000,  16'd2000},
			'{16'd6,     16'd40000, 16'd40020},
			'{16'd2,     16'd1,     16'd65535}
		};
		for (int i = 0; i < SLOTS; i++) begin
			m_valid[i] = 1'b0;
			m_mac[i] = '0;
			m_iip[i] = '0;
			m_ipt[i] = '0;
			m_rip[i] = '0;
			m_port[i] = '0;
			m_seen[i] = '0;
		end
		m_now = '0;
		m_cand = 16'd1024;
		m_timeout = 16'd300;
		m_min = 16'd1024;
		m_max = 16'd65535;

		add_row(FN_IN,   '0, '0, '0, '0, '0, 1, ST_NOTFOUND);
		add_row(FN_IN,   '1, '1, '1, '1, '1, 1, ST_NOTFOUND);
		add_row(FN_TICK, '0, '0, '0, '0, '0, 1, ST_TICK);
		add_row(FN_RSVD, '1, '1, '1, '1, '1, 1, ST_NOTFOUND);
		add_row(FN_OUT,  '1, '1, '1, '1, '0, 0, ST_NEW);
		add_row(FN_OUT,  '0, '0, '0, '0, '1, 0, ST_NEW);
		add_row(FN_OUT,  '1, 48'h1234, '1, '1, '0, 0, ST_HIT);
		add_row(FN_IN,   '0, '0, '0, '1, 16'd1024, 0, ST_HIT);
		add_row(FN_IN,   '0, '0, '0, '0, 16'd1025, 0, ST_HIT);
		add_row(FN_IN,   '0, '0, '0, '0, 16'd1024, 1, ST_NOTFOUND);
		add_row(FN_OUT,  '1, 48'hA5A5_5A5A_A5A5, '0, '1, '0, 0, ST_NEW);
		add_row(FN_OUT,  '1, 48'h5A5A_A5A5_5A5A, '1, '0, '0, 0, ST_NEW);
		add_row(FN_OUT,  '0, '1, '1, '1, '0, 0, ST_NEW);
		add_row(FN_TICK, '0, '0, '0, '0, '0, 1, ST_TICK);
		add_row(FN_IN,   '0, '0, '0, '1, 16'd1024, 0, ST_HIT);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[k])
			send(dir_rows[k].pkt, draw_gap(), dir_rows[k].typed, dir_rows[k].status);
		in_valid <= 1'b0;
		drain();

		per_phase = N_RANDOM / 7;
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_TIMEOUT, phase_cfg[ph][0]);
			write_reg(REG_MIN_PORT, phase_cfg[ph][1]);
			write_reg(REG_MAX_PORT, phase_cfg[ph][2]);
			calm = (ph == 2);
			for (int n = 0; n < per_phase; n++) begin
				// hold off until the table has answered everything
				if (ph == 3 && n == per_phase / 2) begin
					in_valid <= 1'b0;
					do
						@(posedge clk);
					while (pending.size() != 0);
				end
				send(random_item(), draw_gap());
			end
			in_valid <= 1'b0;
			calm = 0;
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#40000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ filelist.f @@
src/natt_pkg.sv
src/nat_translation_table.sv
dv/tb.sv
